>>> rtl/pli_pkg.sv
// Shared types and constants for the positional list block.
// No dependencies; used by the interfaces, the storage cell and the top level.
`timescale 1ns / 1ps
`default_nettype none
package pli_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int CNT_W  = 5;
  localparam int STAT_W = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_UP   = 2'd1,
    OP_DOWN = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/pli_if.sv
// Valid/ready channel interfaces for request and result of the positional list.
// Depends on pli_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface pli_in_if;
  import pli_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [POS_W-1:0]          position;
  logic signed [DATA_W-1:0]  value;

  modport source (output valid, output req_type, output position, output value,
                  input ready);
  modport sink   (input valid, input req_type, input position, input value,
                  output ready);
endinterface

interface pli_out_if;
  import pli_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  removed_value;
  logic [STAT_W-1:0]         status;
  logic [CNT_W-1:0]          count;

  modport source (output valid, output removed_value, output status, output count,
                  input ready);
  modport sink   (input valid, input removed_value, input status, input count,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/pli_cell.sv
// One storage cell of the list: holds an entry, shifts up/down or loads.
// Depends on pli_pkg for the control struct and widths.
`timescale 1ns / 1ps
`default_nettype none
module pli_cell #(
  parameter int IDX  = 0,
  parameter int CMPW = 5
) (
  input  wire                              clk,
  input  wire pli_pkg::cell_ctl_t          ctl,
  input  wire logic signed [pli_pkg::DATA_W-1:0] prev_val,
  input  wire logic signed [pli_pkg::DATA_W-1:0] next_val,
  output logic signed [pli_pkg::DATA_W-1:0]      val,
  output logic signed [pli_pkg::DATA_W-1:0]      hit_val
);
  import pli_pkg::*;

  localparam logic [CMPW-1:0] MY_IDX = CMPW'(IDX);

  logic signed [DATA_W-1:0] entry_r, entry_nxt;
  logic [CMPW-1:0]          pos_x;
  logic                     at_pos, above_pos;

  assign pos_x     = CMPW'(ctl.position);
  assign at_pos    = (MY_IDX == pos_x);
  assign above_pos = (MY_IDX > pos_x);

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      OP_UP: begin
        if (above_pos) begin
          entry_nxt = prev_val;
        end else if (at_pos) begin
          entry_nxt = ctl.value;
        end
      end
      OP_DOWN: begin
        if (above_pos || at_pos) begin
          entry_nxt = next_val;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign val     = entry_r;
  assign hit_val = at_pos ? entry_r : '0;

endmodule
`default_nettype wire

>>> rtl/positional_list_insert_remove.sv
// Positional list with insert/remove at an index, built as a row of cells.
// Depends on pli_pkg, pli_in_if/pli_out_if and pli_cell.
//
// Usage:
//   in_ch carries one request per handshake: req_type (0 insert, 1 remove),
//   position and value. out_ch returns one result per request: removed_value,
//   status (done, invalid position, list full) and the count afterwards.
//   Latency: the result is valid the cycle after the request is accepted.
//   Throughput: one request per cycle while results are taken; every cell shifts, holds or loads in
//   the accept cycle and the count register updates alongside.
//   The removed entry is picked by a one-hot select across the cells.
//   Reset (rst_n low, synchronous) empties the list and drops any pending
//   result; cell contents are not cleared and are never read until written.
//   When the receiver stalls, the result register holds its value and
//   in_ch.ready stays low until that result is taken; a request is accepted
//   in the same cycle the held result leaves.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_insert_remove #(
  parameter int DEPTH = 16
) (
  input  wire      clk,
  input  wire      rst_n,
  pli_in_if.sink   in_ch,
  pli_out_if.source out_ch
);
  import pli_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]            count_r, count_nxt;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] removed_r, removed_nxt;
  status_t                  status_r, status_nxt;
  logic [CNT_W-1:0]         cnt_out_r;

  logic                     acc;
  logic [CMPW-1:0]          pos_x, cnt_x, cnt_nxt_x;
  logic signed [DATA_W-1:0] hit_or;
  cell_ctl_t                ctl;

  logic signed [DATA_W-1:0] ent [DEPTH];
  logic signed [DATA_W-1:0] hit [DEPTH];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign pos_x       = CMPW'(in_ch.position);
  assign cnt_x       = CMPW'(count_r);

  always_comb begin
    hit_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_or = hit_or | hit[i];
    end
  end

  always_comb begin
    status_nxt   = ST_DONE;
    removed_nxt  = '0;
    count_nxt    = count_r;
    ctl.op       = OP_HOLD;
    ctl.position = in_ch.position;
    ctl.value    = in_ch.value;
    if (!in_ch.req_type) begin
      if (pos_x > cnt_x) begin
        status_nxt = ST_BADPOS;
      end else if (count_r == CW'(DEPTH)) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + 1'b1;
        if (acc) begin
          ctl.op = OP_UP;
        end
      end
    end else begin
      if (pos_x >= cnt_x) begin
        status_nxt = ST_BADPOS;
      end else begin
        removed_nxt = hit_or;
        count_nxt   = count_r - 1'b1;
        if (acc) begin
          ctl.op = OP_DOWN;
        end
      end
    end
  end

  assign cnt_nxt_x = CMPW'(count_nxt);

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] prev_v, next_v;
    if (g == 0) begin : g_first
      assign prev_v = in_ch.value;
    end else begin : g_mid_lo
      assign prev_v = ent[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_v = ent[g];
    end else begin : g_mid_hi
      assign next_v = ent[g+1];
    end
    pli_cell #(
      .IDX  (g),
      .CMPW (CMPW)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .prev_val (prev_v),
      .next_val (next_v),
      .val      (ent[g]),
      .hit_val  (hit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      removed_r <= removed_nxt;
      status_r  <= status_nxt;
      cnt_out_r <= cnt_nxt_x[CNT_W-1:0];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.removed_value = removed_r;
  assign out_ch.status        = status_r;
  assign out_ch.count         = cnt_out_r;

endmodule
`default_nettype wire

>>> bench/pli_tb_pkg.sv
// Bench-side request codes and the result record for the positional list.
// Depends on pli_pkg; used by the checker and the testbench top.
`timescale 1ns / 1ps
package pli_tb_pkg;
  import pli_pkg::*;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    status_t                  status;
    logic [CNT_W-1:0]         count;
  } list_result_t;

endpackage

>>> bench/pli_list_checker.sv
// Watches both channels of the positional list, tracks the list contents and
// checks every result in order. Depends on pli_pkg, pli_tb_pkg and the channel interfaces.
`timescale 1ns / 1ps
module pli_list_checker #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  pli_in_if    in_ch,
  pli_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  import pli_pkg::*;
  import pli_tb_pkg::*;

  logic signed [DATA_W-1:0] list_cells [DEPTH];
  int unsigned              list_len;
  list_result_t             awaited_results [$];
  int                       errors;

  task automatic apply_request(input logic req, input logic [POS_W-1:0] pos,
                               input logic signed [DATA_W-1:0] val,
                               output list_result_t res);
    res.removed_value = '0;
    res.status        = ST_DONE;
    if (req == REQ_INSERT) begin
      if (pos > list_len) begin
        res.status = ST_BADPOS;
      end else if (list_len >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        for (int k = list_len; k > pos; k--) list_cells[k] = list_cells[k-1];
        list_cells[pos] = val;
        list_len++;
      end
    end else begin
      if (pos >= list_len) begin
        res.status = ST_BADPOS;
      end else begin
        res.removed_value = list_cells[pos];
        for (int k = pos; k + 1 < list_len; k++) list_cells[k] = list_cells[k+1];
        list_len--;
      end
    end
    res.count = list_len[CNT_W-1:0];
  endtask

  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (!rst_n) begin
      list_len = 0;
      awaited_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.removed_value, out_ch.status, out_ch.count};
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result: removed %0d status %0d count %0d",
                   $time, got.removed_value, got.status, got.count);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected removed %0d status %0d count %0d, got removed %0d status %0d count %0d",
                     $time, want.removed_value, want.status, want.count,
                     got.removed_value, got.status, got.count);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        apply_request(in_ch.req_type, in_ch.position, in_ch.value, want);
        awaited_results.push_back(want);
      end
    end
    fail_count <= errors;
    pending    <= awaited_results.size();
  end

endmodule

>>> bench/positional_list_insert_remove_tb.sv
// Testbench top for positional_list_insert_remove: clock, reset, request
// stimulus, result back-pressure and verdict. Depends on pli_list_checker and the RTL.
`timescale 1ns / 1ps
module positional_list_insert_remove_tb;
  import pli_pkg::*;
  import pli_tb_pkg::*;

  localparam int DEPTH      = 16;
  localparam int N_RANDOM   = 600;
  localparam int LONG_HOLD  = 300;
  localparam int IDLE_LIMIT = 2000;

  logic clk;
  logic rst_n;
  bit   tx_fast;
  bit   rx_fast;
  bit   long_hold;
  int   fill;
  int   fail_count;
  int   pending;
  int   idle_cycles;

  pli_in_if  in_ch ();
  pli_out_if out_ch ();

  positional_list_insert_remove #(.DEPTH(DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pli_list_checker #(.DEPTH(DEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int draw_gap(input bit fast);
    return fast ? 0 : $urandom_range(0, 14);
  endfunction

  // fill tracks the list length to steer positions toward valid ones and to fill the list
  task automatic issue_request(input logic req, input logic [POS_W-1:0] pos,
                               input logic signed [DATA_W-1:0] val);
    int gap;
    gap = draw_gap(tx_fast);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.position <= pos;
    in_ch.value    <= val;
    do @(posedge clk); while (!in_ch.ready);
    if (req == REQ_INSERT) begin
      if (pos <= fill && fill < DEPTH) fill++;
    end else if (pos < fill) begin
      fill--;
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int                       ins_pct;
    logic                     req;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= REQ_INSERT;
    in_ch.position <= '0;
    in_ch.value    <= '0;
    fill    = 0;
    ins_pct = 50;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    issue_request(REQ_REMOVE, 5'd0, 32'sd5);
    issue_request(REQ_INSERT, 5'd1, 32'sd7);
    issue_request(REQ_INSERT, 5'd0, 32'sh7fffffff);
    issue_request(REQ_INSERT, 5'd1, 32'sh80000000);
    issue_request(REQ_INSERT, 5'd1, -32'sd1);
    issue_request(REQ_REMOVE, 5'd1, 32'sd0);
    issue_request(REQ_REMOVE, 5'd2, 32'sd0);
    issue_request(REQ_INSERT, 5'd31, 32'sd3);
    issue_request(REQ_REMOVE, 5'd31, 32'sd0);
    while (fill < DEPTH) begin
      issue_request(REQ_INSERT, POS_W'($urandom_range(0, fill)), $urandom);
    end
    issue_request(REQ_INSERT, 5'd0, 32'sd11);
    issue_request(REQ_INSERT, 5'd16, 32'sd12);
    issue_request(REQ_INSERT, 5'd17, 32'sd13);
    issue_request(REQ_REMOVE, 5'd15, 32'sd0);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 80;
          1: ins_pct = 50;
          default: ins_pct = 20;
        endcase
        tx_fast = ($urandom_range(0, 3) == 0);
        rx_fast = ($urandom_range(0, 3) == 0);
      end
      if (n == 150) begin
        long_hold = 1'b1;
        tx_fast   = 1'b1;
      end
      if (n == 300) wait_drained();
      req = ($urandom_range(0, 99) < ins_pct) ? REQ_INSERT : REQ_REMOVE;
      if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 31));
      else if (req == REQ_INSERT) pos = POS_W'($urandom_range(0, fill));
      else pos = (fill == 0) ? '0 : POS_W'($urandom_range(0, fill - 1));
      case ($urandom_range(0, 9))
        0: val = 32'sh7fffffff;
        1: val = 32'sh80000000;
        default: val = $urandom;
      endcase
      issue_request(req, pos, val);
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("positional_list_insert_remove test passed");
    end else begin
      $display("positional_list_insert_remove test failed");
    end
    $finish;
  end

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end
      stall = draw_gap(rx_fast);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("positional_list_insert_remove test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> sim.f
rtl/pli_pkg.sv
rtl/pli_if.sv
rtl/pli_cell.sv
rtl/positional_list_insert_remove.sv
bench/pli_tb_pkg.sv
bench/pli_list_checker.sv
bench/positional_list_insert_remove_tb.sv
